// File: hw/rtl/tfcm_pkg.sv
// Shared types, constants and ROM builder for the transfer function color map unit.
`default_nettype none

package tfcm_pkg;

    // Default sizes
    localparam int TableDepthDefault = 256;
    localparam int ExpDepthDefault   = 256;

    // exp(-x) ROM spans x in [0, ExpSpan]
    localparam int ExpSpan = 16;

    // Register stages from request transfer to the result register
    localparam int NumStages = 10;

    // Table colors are normalized by 255 * 255 (alpha times channel)
    localparam logic [63:0] ColorDivisor = 64'd65025;
    // Reciprocal for the divide by ColorDivisor, exact for 32-bit dividends
    localparam logic [32:0] DivRecip =
        33'(((64'd1 << 48) + ColorDivisor - 64'd1) / ColorDivisor);

    // Transfer function modes
    typedef enum logic [2:0] {
        MODE_CONSTANT     = 3'd0,
        MODE_TOPHAT       = 3'd1,
        MODE_GAUSS        = 3'd2,
        MODE_TABLE        = 3'd3,
        MODE_TOPHAT_TABLE = 3'd4,
        MODE_GAUSS_TABLE  = 3'd5,
        MODE_LINEAR       = 3'd6
    } tfcm_mode_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MODE         = 3'd0,
        CFG_WINDOW       = 3'd1,
        CFG_GAUSS        = 3'd2,
        CFG_TABLE_MAP    = 3'd3,
        CFG_BASE_COLOR   = 3'd4,
        CFG_END_COLOR    = 3'd5,
        CFG_TABLE_LENGTH = 3'd6
    } tfcm_cfg_t;

    // One color triple: [0] red, [1] green, [2] blue
    typedef logic [2:0][31:0] tfcm_rgb_t;

    // One exp(-x) ROM sample: e^(-step * pos) in Q1.16, step in Q32.32
    function automatic logic [16:0] exp_rom_entry(input logic [63:0] step,
                                                  input int unsigned pos);
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] e;
        term = 64'h1_0000_0000;
        q    = term;
        e    = term;
        // Taylor series of e^(-step)
        for (int k = 1; k <= 16; k++) begin
            term = ((term * step) >> 32) / 64'(k);
            if (k[0]) begin
                q = q - term;
            end
            else begin
                q = q + term;
            end
        end
        for (int unsigned i = 0; i < pos; i++) begin
            e = (e * q) >> 32;
        end
        return 17'((e + 64'd32768) >> 16);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/transfer_function_color_map_unit.sv
// Top level of the transfer function color map unit.
//
// Usage:
//  Request channel (req_valid / req_stall): a transfer with req_type 0 maps
//  sample_value to one result; req_type 1 loads one color table entry and
//  gives no result. A transfer happens when valid is high and stall is low.
//  Result channel (res_valid / res_stall): in_range plus Q16.16 RGB.
//  Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data):
//  always ready; write only while no sample is in flight.
//  Throughput: one request per cycle while no result is stalled, set
//  by the ten-stage pipeline, the dual-read color table memory and the
//  exp ROM. A table write lands in the memory at the stage where
//  samples read it, so requests keep their order with no interlock.
//  When the receiver stalls a waiting result the whole pipeline holds and
//  req_stall rises in the same cycle.
//  Reset loads the register reset values and empties the pipeline. The
//  color table holds no defined contents until its entries are written.
`default_nettype none

module transfer_function_color_map_unit
    import tfcm_pkg::*;
#(
    parameter int TABLE_DEPTH     = TableDepthDefault,
    parameter int EXP_TABLE_DEPTH = ExpDepthDefault
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Request channel
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic               req_type,
    input  wire logic signed [31:0] sample_value,
    input  wire logic        [7:0]  entry_index,
    input  wire logic        [7:0]  entry_red,
    input  wire logic        [7:0]  entry_green,
    input  wire logic        [7:0]  entry_blue,
    input  wire logic        [7:0]  entry_alpha,
    // Result channel
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic                    in_range,
    output logic             [31:0] out_red,
    output logic             [31:0] out_green,
    output logic             [31:0] out_blue,
    // Configuration channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [2:0]  cfg_index,
    input  wire logic        [63:0] cfg_data
);

    localparam int TaW = $clog2(TABLE_DEPTH);

    // Configuration registers
    logic [2:0]  mode_reg;
    logic [63:0] window_reg;
    logic [63:0] gauss_reg;
    logic [63:0] tmap_reg;
    logic [47:0] base_reg;
    logic [47:0] end_reg;
    logic [8:0]  tlen_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_CONSTANT;
            window_reg <= '0;
            gauss_reg  <= '0;
            tmap_reg   <= '0;
            base_reg   <= '0;
            end_reg    <= '0;
            tlen_reg   <= 9'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:         mode_reg   <= cfg_data[2:0];
                CFG_WINDOW:       window_reg <= cfg_data;
                CFG_GAUSS:        gauss_reg  <= cfg_data;
                CFG_TABLE_MAP:    tmap_reg   <= cfg_data;
                CFG_BASE_COLOR:   base_reg   <= cfg_data[47:0];
                CFG_END_COLOR:    end_reg    <= cfg_data[47:0];
                CFG_TABLE_LENGTH: tlen_reg   <= cfg_data[8:0];
                default:          ;
            endcase
        end
    end

    // Pipeline advance: hold everything while a finished result is stalled
    logic en;

    assign en        = !(res_valid && res_stall);
    assign req_stall = !en;

    // Valid bits: samples through all stages, table writes up to stage 3
    logic [NumStages:1] vld_reg;
    logic [3:1]         wrv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            wrv_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NumStages-1:1], req_valid && !req_type};
            wrv_reg <= {wrv_reg[2:1], req_valid && req_type};
        end
    end

    // Stage payload registers
    logic signed [31:0] v1_reg;
    logic        [7:0]  widx_reg [1:3];
    logic        [31:0] wdat_reg [1:3];
    logic signed [32:0] dt2_reg;
    logic        [63:0] pt3_reg;
    logic               tpos3_reg;
    logic        [31:0] e0_reg;
    logic        [31:0] e1_reg;
    logic        [15:0] t4_reg;
    logic        [16:0] tl4_reg;
    logic        [23:0] la5_reg;
    logic        [23:0] lc5_reg [3];
    logic        [47:0] w6_reg  [3];
    logic        [47:0] w7_reg  [3];
    logic        [47:0] w8_reg  [3];
    logic        [39:0] ph8_reg [3];
    logic        [39:0] pl8_reg [3];
    logic               full8_reg;
    logic        [31:0] q9_reg  [3];
    logic               inr_reg [2:NumStages];
    tfcm_rgb_t          col_reg [2:NumStages];

    logic        [16:0] mult7;

    // Color table memory, RGBA packed R low
    logic [31:0] ctab_mem [TABLE_DEPTH];

    // Gaussian weight, aligned with stage 7
    tfcm_gauss_unit #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_gauss (
        .clk         (clk),
        .en          (en),
        .sample      (v1_reg),
        .gauss_params(gauss_reg),
        .mult        (mult7)
    );

    // Interpolate one 8-bit table component, result in units of 1/65536
    function automatic logic [23:0] lerp8(input logic [7:0] c0, input logic [7:0] c1,
                                          input logic [15:0] t);
        logic signed [8:0]  dc;
        logic signed [25:0] acc;
        dc  = $signed({1'b0, c1}) - $signed({1'b0, c0});
        acc = $signed({2'b0, c0, 16'b0}) + 26'(dc) * $signed({10'b0, t});
        return acc[23:0];
    endfunction

    // Linear ramp channel: (a * 65536 + (b - a) * t) >> 15
    function automatic logic [31:0] ramp(input logic [15:0] a, input logic [15:0] b,
                                         input logic [16:0] t);
        logic signed [16:0] dc;
        logic signed [34:0] acc;
        dc  = $signed({1'b0, b}) - $signed({1'b0, a});
        acc = $signed({3'b0, a, 16'b0}) + 35'(dc) * $signed({18'b0, t});
        return {15'b0, acc[31:15]};
    endfunction

    // Stage 1: window check and constant/tophat color
    logic      inr1_c;
    tfcm_rgb_t cconst_c;

    always_comb
    begin
        inr1_c = (v1_reg >= $signed(window_reg[63:32])) &&
                 (v1_reg <= $signed(window_reg[31:0]));
        for (int k = 0; k < 3; k++)
        begin
            cconst_c[k] = (v1_reg > 32'sd0) ?
                32'((48'(base_reg[47-16*k -: 16]) * 48'(v1_reg[30:0])) >> 15) : '0;
        end
    end

    // Stage 3: table position, entry addresses and ramp position
    logic [31:0]    len_c;
    logic [TaW-1:0] lenm1_c;
    logic [31:0]    phi_c;
    logic [TaW-1:0] left_c;
    logic [TaW-1:0] right_c;
    logic [15:0]    t3_c;
    logic [16:0]    tl3_c;
    logic           wr_ok_c;

    always_comb
    begin
        if (tlen_reg == '0)
        begin
            len_c = 32'd1;
        end
        else if (32'(tlen_reg) > TABLE_DEPTH)
        begin
            len_c = 32'(TABLE_DEPTH);
        end
        else
        begin
            len_c = 32'(tlen_reg);
        end
        lenm1_c = TaW'(len_c - 32'd1);
        phi_c   = pt3_reg[63:32];
        left_c  = '0;
        t3_c    = '0;
        if (tpos3_reg)
        begin
            if (phi_c >= 32'(lenm1_c))
            begin
                left_c = lenm1_c;
            end
            else
            begin
                left_c = TaW'(phi_c);
                t3_c   = pt3_reg[31:16];
            end
        end
        right_c = (left_c < lenm1_c) ? left_c + 1'b1 : lenm1_c;
        if (!tpos3_reg)
        begin
            tl3_c = '0;
        end
        else if (phi_c != '0)
        begin
            tl3_c = 17'h10000;
        end
        else
        begin
            tl3_c = {1'b0, pt3_reg[31:16]};
        end
        wr_ok_c = 32'(widx_reg[3]) < TABLE_DEPTH;
    end

    // Stage 4: table lerp and linear ramp color
    logic [23:0] la4_c;
    logic [23:0] lc4_c [3];
    tfcm_rgb_t   clin_c;

    always_comb
    begin
        la4_c = lerp8(e0_reg[31:24], e1_reg[31:24], t4_reg);
        for (int k = 0; k < 3; k++)
        begin
            lc4_c[k]  = lerp8(e0_reg[8*k +: 8], e1_reg[8*k +: 8], t4_reg);
            clin_c[k] = ramp(base_reg[47-16*k -: 16], end_reg[47-16*k -: 16], tl4_reg);
        end
    end

    // Stage 7: Gaussian color and partial products of the weighted table color
    tfcm_rgb_t   cgauss_c;
    logic [39:0] ph7_c [3];
    logic [39:0] pl7_c [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cgauss_c[k] = 32'((34'(base_reg[47-16*k -: 16]) * 34'(mult7)) >> 15);
            ph7_c[k]    = 40'(w7_reg[k][47:24]) * 40'(mult7[15:0]);
            pl7_c[k]    = 40'(w7_reg[k][23:0]) * 40'(mult7[15:0]);
        end
    end

    // Stage 8: weighted product scaled down to the dividend
    logic        gtab_c;
    logic [63:0] sum8_c [3];
    logic [31:0] q8_c   [3];

    always_comb
    begin
        gtab_c = (mode_reg == MODE_GAUSS_TABLE) && !full8_reg;
        for (int k = 0; k < 3; k++)
        begin
            sum8_c[k] = (64'(ph8_reg[k]) << 24) + 64'(pl8_reg[k]);
            q8_c[k]   = gtab_c ? sum8_c[k][63:32] : w8_reg[k][47:16];
        end
    end

    // Stage 9: divide by 255 * 255 through the reciprocal
    tfcm_rgb_t ctab_c;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ctab_c[k] = 32'((65'(q9_reg[k]) * 65'(DivRecip)) >> 48);
        end
    end

    // Color pipeline: each mode loads its result at the stage where it is ready
    logic      tmode_c;
    tfcm_rgb_t col_next [2:NumStages];

    always_comb
    begin
        tmode_c = (mode_reg == MODE_TABLE) || (mode_reg == MODE_TOPHAT_TABLE) ||
                  (mode_reg == MODE_GAUSS_TABLE);
        col_next[2] = (inr1_c && ((mode_reg == MODE_CONSTANT) ||
                                  (mode_reg == MODE_TOPHAT))) ? cconst_c : '0;
        for (int s = 3; s <= NumStages; s++)
        begin
            col_next[s] = col_reg[s-1];
        end
        if (inr_reg[4] && (mode_reg == MODE_LINEAR))
        begin
            col_next[5] = clin_c;
        end
        if (inr_reg[7] && (mode_reg == MODE_GAUSS))
        begin
            col_next[8] = cgauss_c;
        end
        if (inr_reg[9] && tmode_c)
        begin
            col_next[10] = ctab_c;
        end
    end

    // Payload registers and table memory
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg      <= sample_value;
            widx_reg[1] <= entry_index;
            wdat_reg[1] <= {entry_alpha, entry_blue, entry_green, entry_red};
            widx_reg[2] <= widx_reg[1];
            wdat_reg[2] <= wdat_reg[1];
            widx_reg[3] <= widx_reg[2];
            wdat_reg[3] <= wdat_reg[2];
            dt2_reg     <= 33'(v1_reg) - 33'($signed(tmap_reg[63:32]));
            pt3_reg     <= 64'(dt2_reg[31:0]) * 64'(tmap_reg[31:0]);
            tpos3_reg   <= dt2_reg > 33'sd0;
            // table write and reads share stage 3, so order is kept
            if (wrv_reg[3] && wr_ok_c)
            begin
                ctab_mem[TaW'(widx_reg[3])] <= wdat_reg[3];
            end
            e0_reg      <= ctab_mem[left_c];
            e1_reg      <= ctab_mem[right_c];
            t4_reg      <= t3_c;
            tl4_reg     <= tl3_c;
            la5_reg     <= la4_c;
            full8_reg   <= mult7[16];
            for (int k = 0; k < 3; k++)
            begin
                lc5_reg[k] <= lc4_c[k];
                w6_reg[k]  <= 48'(la5_reg) * 48'(lc5_reg[k]);
                w7_reg[k]  <= w6_reg[k];
                w8_reg[k]  <= w7_reg[k];
                ph8_reg[k] <= ph7_c[k];
                pl8_reg[k] <= pl7_c[k];
                q9_reg[k]  <= q8_c[k];
            end
            inr_reg[2] <= inr1_c;
            for (int s = 3; s <= NumStages; s++)
            begin
                inr_reg[s] <= inr_reg[s-1];
            end
            for (int s = 2; s <= NumStages; s++)
            begin
                col_reg[s] <= col_next[s];
            end
        end
    end

    // Result register is the last stage
    assign res_valid = vld_reg[NumStages];
    assign in_range  = inr_reg[NumStages];
    assign out_red   = col_reg[NumStages][0];
    assign out_green = col_reg[NumStages][1];
    assign out_blue  = col_reg[NumStages][2];

endmodule

`default_nettype wire

// File: hw/rtl/tfcm_gauss_unit.sv
// Gaussian weight pipeline: exp(-(v - mean)^2 * scale) from an interpolated ROM.
`default_nettype none

module tfcm_gauss_unit
    import tfcm_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = ExpDepthDefault
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [31:0] sample,
    input  wire logic        [63:0] gauss_params,
    output logic             [16:0] mult
);

    localparam int ExpAw = $clog2(EXP_TABLE_DEPTH + 1);
    localparam logic [63:0] ExpStep = (64'(ExpSpan) << 32) / EXP_TABLE_DEPTH;

    // Constant exp ROM, EXP_TABLE_DEPTH + 1 samples
    logic [16:0] exp_rom [EXP_TABLE_DEPTH + 1];

    for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_rom
        assign exp_rom[gi] = exp_rom_entry(ExpStep, gi);
    end

    logic        [31:0] mg_reg;
    logic        [63:0] p_reg;
    logic        [63:0] a_reg;
    logic        [63:0] b_reg;
    logic        [19:0] x_reg;
    logic               xz_reg;
    logic        [16:0] r0_reg;
    logic        [16:0] rd_reg;
    logic        [15:0] fr_reg;
    logic        [16:0] mult_reg;

    logic signed [32:0] d_c;
    logic        [31:0] mg_next;
    logic        [32:0] xs_c;
    logic               xz_next;
    logic        [31:0] pos_c;
    logic   [ExpAw-1:0] idx_c;
    logic   [ExpAw-1:0] idx1_c;
    logic        [16:0] r0_c;
    logic        [16:0] r1_c;

    // Distance from the mean
    always_comb
    begin
        d_c     = 33'(sample) - 33'($signed(gauss_params[63:32]));
        mg_next = d_c[32] ? 32'(-d_c) : d_c[31:0];
    end

    // Exponent range check: x >= ExpSpan gives zero weight
    always_comb
    begin
        xs_c    = 33'(a_reg[19:0]) + 33'(b_reg[63:32]);
        xz_next = (a_reg[63:20] != '0) || (xs_c[32:20] != '0);
    end

    // ROM position and neighbor samples
    always_comb
    begin
        pos_c  = 32'((36'(x_reg) * 36'(EXP_TABLE_DEPTH)) >> 4);
        idx_c  = ExpAw'(pos_c >> 16);
        idx1_c = idx_c + 1'b1;
        r0_c   = exp_rom[idx_c];
        r1_c   = exp_rom[idx1_c];
    end

    // Pipeline registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mg_reg   <= mg_next;
            p_reg    <= 64'(mg_reg) * 64'(mg_reg);
            a_reg    <= 64'(p_reg[63:32]) * 64'(gauss_params[31:0]);
            b_reg    <= 64'(p_reg[31:0]) * 64'(gauss_params[31:0]);
            x_reg    <= xs_c[19:0];
            xz_reg   <= xz_next;
            r0_reg   <= xz_reg ? '0 : r0_c;
            rd_reg   <= xz_reg ? '0 : r0_c - r1_c;
            fr_reg   <= pos_c[15:0];
            mult_reg <= r0_reg - 17'((33'(rd_reg) * 33'(fr_reg)) >> 16);
        end
    end

    assign mult = mult_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tfcm_checker.sv
// Port-level assertions for the transfer function color map unit, with bind.
`default_nettype none

module tfcm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_stall,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic        in_range,
    input wire logic [31:0] out_red,
    input wire logic [31:0] out_green,
    input wire logic [31:0] out_blue
);

    // Out-of-window samples carry no color
    a_zero_color: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !in_range |-> out_red == 32'd0 && out_green == 32'd0 &&
                                   out_blue == 32'd0)
        else $error("out-of-range result with nonzero color");

    // Requests are held back exactly while a result waits on a stall
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (res_valid && res_stall))
        else $error("req_stall does not follow the stalled result");

    // A stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(in_range) &&
            $stable(out_red) && $stable(out_green) && $stable(out_blue))
        else $error("stalled result changed");

endmodule

bind transfer_function_color_map_unit tfcm_checker u_tfcm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_stall(req_stall),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .in_range (in_range),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue)
);

`default_nettype wire

// File: dv/transfer_function_color_map_unit_tb.sv
// Self-checking testbench for the transfer function color map unit.
`default_nettype none

module transfer_function_color_map_unit_tb;
    import tfcm_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 20;
    localparam int PhaseItems = 135;

    typedef struct {
        logic              is_write;
        logic signed [31:0] value;
        logic [7:0]        idx;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        alpha;
    } map_req_t;

    typedef struct {
        logic        hit;
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
    } map_color_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic               req_type;
    logic signed [31:0] sample_value;
    logic [7:0]         entry_index;
    logic [7:0]         entry_red;
    logic [7:0]         entry_green;
    logic [7:0]         entry_blue;
    logic [7:0]         entry_alpha;
    logic               res_valid;
    logic               res_stall;
    logic               in_range;
    logic [31:0]        out_red;
    logic [31:0]        out_green;
    logic [31:0]        out_blue;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;

    // Shadow copies of the register file and the color table
    logic [2:0]  sh_mode;
    logic [63:0] sh_window;
    logic [63:0] sh_gauss;
    logic [63:0] sh_map;
    logic [47:0] sh_base;
    logic [47:0] sh_end;
    logic [8:0]  sh_length;
    logic [31:0] color_lut [256];
    logic [31:0] exp_curve [257];

    map_req_t   pending_reqs [$];
    map_color_t due_colors [$];
    map_req_t   presented;
    int         send_idle;
    int         recv_idle;
    int         mismatches;
    int         cycles;

    transfer_function_color_map_unit uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
        .sample_value(sample_value), .entry_index(entry_index),
        .entry_red(entry_red), .entry_green(entry_green),
        .entry_blue(entry_blue), .entry_alpha(entry_alpha),
        .res_valid(res_valid), .res_stall(res_stall), .in_range(in_range),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // exp(-x) samples over [0,16]: Taylor series for one step, then powers
    function automatic void build_exp_curve();
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] e;
        step = (64'd16 << 32) / 64'd256;
        term = 64'h1_0000_0000;
        q = term;
        e = term;
        for (int k = 1; k <= 16; k++)
        begin
            term = ((term * step) >> 32) / 64'(k);
            if (k % 2 == 1)
                q = q - term;
            else
                q = q + term;
        end
        exp_curve[0] = 32'd65536;
        for (int i = 1; i <= 256; i++)
        begin
            e = (e * q) >> 32;
            exp_curve[i] = 32'((e + 64'd32768) >> 16);
        end
    endfunction

    function automatic logic [31:0] clip32(logic [127:0] x);
        return (x > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    // Gaussian weight in Q1.16
    function automatic logic [63:0] gauss_weight(logic signed [31:0] v);
        longint      d;
        logic [63:0] m;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] pos;
        logic [63:0] ix;
        logic [63:0] fr;
        d = longint'(v) - longint'($signed(sh_gauss[63:32]));
        m = (d < 0) ? 64'(-d) : 64'(d);
        p = m * m;
        s = {32'd0, sh_gauss[31:0]};
        a = {32'd0, p[63:32]} * s;
        if (a >= (64'd16 << 16))
            return 64'd0;
        x = a + (({32'd0, p[31:0]} * s) >> 32);
        if (x >= (64'd16 << 16))
            return 64'd0;
        pos = (x * 64'd256) >> 4;
        ix = pos >> 16;
        fr = {48'd0, pos[15:0]};
        return 64'(exp_curve[ix]) -
               (((64'(exp_curve[ix]) - 64'(exp_curve[ix + 1])) * fr) >> 16);
    endfunction

    // Expected result of one sample under the shadow configuration
    function automatic map_color_t map_sample(logic signed [31:0] v);
        map_color_t   res;
        logic [127:0] ch [3];
        logic [63:0]  mult;
        logic [63:0]  p;
        longint       d;
        longint       len;
        longint       left;
        longint       right;
        longint       t;
        longint       la;
        longint       lc;
        longint       ca;
        longint       cb;
        logic [31:0]  e0;
        logic [31:0]  e1;
        res = '{hit: 1'b0, red: 32'd0, green: 32'd0, blue: 32'd0};
        for (int k = 0; k < 3; k++)
            ch[k] = 128'd0;
        if (v < $signed(sh_window[63:32]) || v > $signed(sh_window[31:0]))
            return res;
        case (sh_mode)
            MODE_CONSTANT, MODE_TOPHAT:
            begin
                if (v > 0)
                    for (int k = 0; k < 3; k++)
                        ch[k] = (128'(sh_base[47 - 16 * k -: 16]) * 128'(v)) >> 15;
            end
            MODE_GAUSS:
            begin
                mult = gauss_weight(v);
                for (int k = 0; k < 3; k++)
                    ch[k] = (128'(sh_base[47 - 16 * k -: 16]) * 128'(mult)) >> 15;
            end
            MODE_TABLE, MODE_TOPHAT_TABLE, MODE_GAUSS_TABLE:
            begin
                len = longint'(sh_length);
                if (len < 1)
                    len = 1;
                if (len > 256)
                    len = 256;
                d = longint'(v) - longint'($signed(sh_map[63:32]));
                left = 0;
                t = 0;
                if (d > 0)
                begin
                    p = 64'(d) * {32'd0, sh_map[31:0]};
                    if (longint'(p[63:32]) >= len - 1)
                        left = len - 1;
                    else
                    begin
                        left = longint'(p[63:32]);
                        t = longint'(p[31:16]);
                    end
                end
                right = (left + 1 < len) ? left + 1 : len - 1;
                e0 = color_lut[left];
                e1 = color_lut[right];
                la = longint'(e0[31:24]) * 65536 +
                     (longint'(e1[31:24]) - longint'(e0[31:24])) * t;
                mult = (sh_mode == MODE_GAUSS_TABLE) ? gauss_weight(v) : 64'd65536;
                for (int k = 0; k < 3; k++)
                begin
                    ca = longint'(e0[8 * k +: 8]);
                    cb = longint'(e1[8 * k +: 8]);
                    lc = ca * 65536 + (cb - ca) * t;
                    ch[k] = (128'(la) * 128'(lc) * 128'(mult)) / (128'd65025 << 32);
                end
            end
            MODE_LINEAR:
            begin
                d = longint'(v) - longint'($signed(sh_map[63:32]));
                t = 0;
                if (d > 0)
                begin
                    p = 64'(d) * {32'd0, sh_map[31:0]};
                    t = (p[63:32] != 0) ? 65536 : longint'(p[47:16]);
                end
                for (int k = 0; k < 3; k++)
                begin
                    ca = longint'(sh_base[47 - 16 * k -: 16]);
                    cb = longint'(sh_end[47 - 16 * k -: 16]);
                    ch[k] = 128'((ca * 65536 + (cb - ca) * t) >> 15);
                end
            end
            default:
            begin
            end
        endcase
        res.hit = 1'b1;
        res.red = clip32(ch[0]);
        res.green = clip32(ch[1]);
        res.blue = clip32(ch[2]);
        return res;
    endfunction

    // Register write over the config channel, mirrored into the shadow copy
    task automatic write_reg(tfcm_cfg_t idx, logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:         sh_mode = val[2:0];
            CFG_WINDOW:       sh_window = val;
            CFG_GAUSS:        sh_gauss = val;
            CFG_TABLE_MAP:    sh_map = val;
            CFG_BASE_COLOR:   sh_base = val[47:0];
            CFG_END_COLOR:    sh_end = val[47:0];
            CFG_TABLE_LENGTH: sh_length = val[8:0];
            default:
            begin
            end
        endcase
    endtask

    // Sample at the falling edge until nothing is queued, presented or expected
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || due_colors.size() != 0);
    endtask

    // Wait until no request or result is outstanding
    task automatic drain();
        wait_idle();
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic map_req_t sample_req(logic signed [31:0] v);
        map_req_t r;
        r.is_write = 1'b0;
        r.value = v;
        r.idx = 8'($urandom);
        r.red = 8'($urandom);
        r.green = 8'($urandom);
        r.blue = 8'($urandom);
        r.alpha = 8'($urandom);
        return r;
    endfunction

    function automatic map_req_t entry_req(logic [7:0] idx);
        map_req_t r;
        r = sample_req($urandom);
        r.is_write = 1'b1;
        r.idx = idx;
        return r;
    endfunction

    // Samples clustered near the interesting points of the current setup
    function automatic logic signed [31:0] next_sample();
        logic signed [31:0] center;
        case ($urandom_range(4))
            0: center = sh_window[63:32];
            1: center = sh_window[31:0];
            2: center = sh_gauss[63:32];
            3: center = sh_map[63:32];
            default: return $urandom;
        endcase
        return center + ($signed(32'($urandom)) >>> $urandom_range(4, 30));
    endfunction

    // Random setup for one phase; the phase number picks mode and extremes
    task automatic setup_phase(int ph);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = -32'($urandom_range(0, 64 << 16));
        hi = 32'($urandom_range(0, 64 << 16));
        if (ph % 4 == 0)
            write_reg(CFG_WINDOW, {32'h8000_0000, 32'h7FFF_FFFF});
        else if (ph == 6)
            write_reg(CFG_WINDOW, {hi + 32'd1, lo});
        else
            write_reg(CFG_WINDOW, {lo, hi});
        write_reg(CFG_MODE, 64'(ph % 7));
        write_reg(CFG_GAUSS, {32'($signed(32'($urandom)) >>> $urandom_range(8, 24)),
                              32'($urandom >> $urandom_range(0, 31))});
        write_reg(CFG_TABLE_MAP, {-32'($urandom_range(0, 16 << 16)),
                                  32'($urandom >> $urandom_range(6, 24))});
        if (ph % 2 == 1)
        begin
            write_reg(CFG_BASE_COLOR, 64'hFFFF_FFFF_FFFF);
            write_reg(CFG_END_COLOR, 64'h0);
        end
        else
        begin
            write_reg(CFG_BASE_COLOR, {$urandom, $urandom});
            write_reg(CFG_END_COLOR, {$urandom, $urandom});
        end
        case (ph % 3)
            0: write_reg(CFG_TABLE_LENGTH, 64'd256);
            1: write_reg(CFG_TABLE_LENGTH, 64'd1);
            default: write_reg(CFG_TABLE_LENGTH, 64'($urandom_range(1, 256)));
        endcase
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 12)
                pending_reqs.insert(pending_reqs.size(), entry_req(8'($urandom)));
            else
                pending_reqs.insert(pending_reqs.size(), sample_req(next_sample()));
        end
    endtask

    // Request driver: prediction happens when a request transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                if (presented.is_write)
                    color_lut[presented.idx] = {presented.alpha, presented.blue,
                                                presented.green, presented.red};
                else
                    due_colors.insert(due_colors.size(), map_sample(presented.value));
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    presented = pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    req_type <= presented.is_write;
                    sample_value <= presented.value;
                    entry_index <= presented.idx;
                    entry_red <= presented.red;
                    entry_green <= presented.green;
                    entry_blue <= presented.blue;
                    entry_alpha <= presented.alpha;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random receiver stalls
    always @(posedge clk)
    begin
        map_color_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (due_colors.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: in_range=%0b r=%h g=%h b=%h",
                                 in_range, out_red, out_green, out_blue);
                    mismatches++;
                end
                else
                begin
                    want = due_colors.pop_front();
                    if (in_range !== want.hit || out_red !== want.red ||
                        out_green !== want.green || out_blue !== want.blue)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: in_range %0b/%0b r %h/%h g %h/%h b %h/%h",
                                     want.hit, in_range, want.red, out_red,
                                     want.green, out_green, want.blue, out_blue);
                        mismatches++;
                    end
                end
            end
            res_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("transfer_function_color_map_unit_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int tag;
        logic signed [31:0] corner [4];
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = 1'b0;
        sample_value = '0;
        entry_index = '0;
        entry_red = '0;
        entry_green = '0;
        entry_blue = '0;
        entry_alpha = '0;
        res_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle = 33;
        recv_idle = 63;
        mismatches = 0;
        cycles = 0;
        sh_mode = MODE_CONSTANT;
        sh_window = '0;
        sh_gauss = '0;
        sh_map = '0;
        sh_base = '0;
        sh_end = '0;
        sh_length = 9'd256;
        build_exp_curve();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the whole color table so no entry is read unwritten
        for (int i = 0; i < 256; i++)
            pending_reqs.insert(pending_reqs.size(), entry_req(8'(i)));
        pending_reqs[0].red = 8'hFF;
        pending_reqs[0].green = 8'hFF;
        pending_reqs[0].blue = 8'hFF;
        pending_reqs[0].alpha = 8'hFF;
        pending_reqs[255].red = 8'h00;
        pending_reqs[255].green = 8'h00;
        pending_reqs[255].blue = 8'h00;
        pending_reqs[255].alpha = 8'h00;
        drain();

        // Directed: every mode, full window, field extremes
        corner = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 32'sd1};
        write_reg(CFG_WINDOW, {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(CFG_GAUSS, {32'd0, 32'h0001_0000});
        write_reg(CFG_TABLE_MAP, {32'd0, 32'h0010_0000});
        write_reg(CFG_BASE_COLOR, 64'hFFFF_FFFF_FFFF);
        write_reg(CFG_END_COLOR, 64'h0);
        write_reg(CFG_TABLE_LENGTH, 64'd256);
        for (int md = MODE_CONSTANT; md <= MODE_LINEAR; md++)
        begin
            write_reg(CFG_MODE, 64'(md));
            foreach (corner[i])
                pending_reqs.insert(pending_reqs.size(), sample_req(corner[i]));
            drain();
        end

        // Random phases under three idling regimes
        for (int ph = 0; ph < 12; ph++)
        begin
            tag = ph / 4;
            send_idle = (tag == 0) ? 33 : (tag == 1) ? 63 : 0;
            recv_idle = (tag == 0) ? 63 : (tag == 1) ? 33 : 0;
            setup_phase(ph);
            if (ph == 5)
            begin
                // sender holds off until all results are back
                queue_random(PhaseItems / 2);
                wait_idle();
                queue_random(PhaseItems / 2);
            end
            else
                queue_random(PhaseItems);
            drain();
        end

        if (mismatches == 0 && due_colors.size() == 0)
            $display("transfer_function_color_map_unit_tb: PASS");
        else
            $display("transfer_function_color_map_unit_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
